@@ design/qte_pkg.sv @@
package qte_pkg;

	// datapath widths
	localparam int CW = 36;
	localparam int AW = 34;
	localparam int DIV_STEPS = 31;
	localparam int SQRT_STEPS = 31;

	// constants in the fixed-point formats of the datapath
	localparam logic signed [AW-1:0] PI_Q28 = 34'sd843314857;
	localparam logic signed [15:0] PI_Q12 = 16'sd12868;
	localparam logic signed [CW-1:0] ONE_Q28 = 36'sd268435456;
	localparam logic [29:0] BOUND_K = 30'd536870805;

	localparam logic signed [AW-1:0] ATAN_Q28 [10] = '{
		34'sd210828714, 34'sd124459457, 34'sd65760959, 34'sd33381290, 34'sd16755422,
		34'sd8385879, 34'sd4193963, 34'sd2097109, 34'sd1048571, 34'sd524287
	};

	typedef struct packed {
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
	} quat_t;

	typedef enum logic [1:0] {
		LOCK_NONE = 2'd0,
		LOCK_POS = 2'd1,
		LOCK_NEG = 2'd2
	} lock_t;

	typedef struct packed {
		logic signed [15:0] yaw_angle;
		logic signed [15:0] pitch_angle;
		logic signed [15:0] roll_angle;
		lock_t lock_case;
	} euler_t;

	// restoring divider cell contents
	typedef struct packed {
		logic [62:0] rem;
		logic [32:0] den;
		logic [30:0] quo;
	} div_t;

	// integer square root cell contents
	typedef struct packed {
		logic [60:0] rad;
		logic [61:0] root;
	} sqrt_t;

	// vectoring cordic cell contents
	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [AW-1:0] ang;
		logic hold;
	} cord_t;

	// data that rides alongside the divider and square root cells
	typedef struct packed {
		logic signed [CW-1:0] yaw_y;
		logic signed [CW-1:0] yaw_x;
		logic signed [CW-1:0] roll_y;
		logic signed [CW-1:0] roll_x;
		logic [30:0] mag;
		logic rneg;
		logic len_zero;
		lock_t lock;
	} side_t;

	typedef struct packed {
		lock_t lock;
		logic len_zero;
	} tag_t;

	// micro-rotation angle of one cordic cell, in Q.28
	function automatic logic signed [AW-1:0] stage_angle(input int i);
		logic [31:0] iu;
		iu = i;
		if (i < 10)
			return ATAN_Q28[iu[3:0]];
		else if (i <= 28)
			return 34'sd1 <<< (28 - i);
		else
			return '0;
	endfunction

	// quadrant fold ahead of the cordic cells; a zero y fixes the angle
	function automatic cord_t cord_pre(input logic signed [CW-1:0] y,
			input logic signed [CW-1:0] x);
		cord_t c;
		c.x = x;
		c.y = y;
		c.ang = '0;
		c.hold = 1'b0;
		if (y == '0) begin
			c.hold = 1'b1;
			c.ang = x[CW-1] ? PI_Q28 : '0;
		end else if (x[CW-1]) begin
			c.ang = y[CW-1] ? -PI_Q28 : PI_Q28;
			c.x = -x;
			c.y = -y;
		end
		return c;
	endfunction

	// Q.28 to Q4.12, round half up, saturate
	function automatic logic signed [15:0] to_field(input logic signed [CW-1:0] a);
		logic signed [CW:0] t;
		logic signed [CW-16:0] v;
		t = $signed({a[CW-1], a}) + $signed((CW+1)'(32768));
		v = t[CW:16];
		if (v > 32767)
			return 16'sh7fff;
		else if (v < -32768)
			return 16'sh8000;
		else
			return v[15:0];
	endfunction

endpackage

@@ design/quaternion_to_euler_core.sv @@
// Throughput: one request per cycle while the skid is empty; every cell of the divider, square
// root and cordic chains holds a different request, so nothing is shared between requests.
// A stalled output fills a one-entry skid register, which then holds the whole chain.
// Reset (arst_n low) clears the chain valid bits and the output and skid valid flags at once.
module quaternion_to_euler_core #(
	parameter int CORDIC_STAGES = 16
) (
	input logic clk,
	input logic arst_n,
	input logic quat_valid,
	output logic quat_ready,
	input qte_pkg::quat_t quat,
	output logic euler_valid,
	input logic euler_ready,
	output qte_pkg::euler_t euler
);
	import qte_pkg::*;

	localparam int LAT = 4 + DIV_STEPS + 1 + SQRT_STEPS + 1 + CORDIC_STAGES;
	localparam int SIDE_N = DIV_STEPS + SQRT_STEPS + 2;
	localparam int SQ_IDX = DIV_STEPS + 1;

	logic en;
	logic [LAT-1:0] vld_q;

	logic signed [31:0] w2_s1, x2_s1, y2_s1, z2_s1;
	logic signed [31:0] wz_s1, xy_s1, wy_s1, xz_s1, wx_s1, yz_s1;
	logic signed [15:0] w_s1, y_s1;

	logic [32:0] len_s2;
	logic signed [32:0] s_s2;
	logic signed [CW-1:0] yy_s2, yx_s2, ry_s2, rx_s2, sy_s2, sw_s2;

	logic [32:0] len_s3;
	logic signed [32:0] s_s3;
	logic [62:0] bound_s3;
	logic signed [CW-1:0] yy_s3, yx_s3, ry_s3, rx_s3, sy_s3, sw_s3;

	logic signed [63:0] lhs;
	logic signed [63:0] bnd;
	logic pos, neg;
	logic [32:0] s_mag;

	div_t dvc [DIV_STEPS+1];
	side_t side_q [SIDE_N];
	sqrt_t sqc [SQRT_STEPS+1];
	logic [61:0] msq;

	cord_t yc [CORDIC_STAGES+1];
	cord_t pc [CORDIC_STAGES+1];
	cord_t rc [CORDIC_STAGES+1];
	tag_t tag_q [CORDIC_STAGES+1];

	logic signed [CW-1:0] yaw2;
	euler_t res;
	euler_t out_q;
	euler_t skid_q;
	logic out_vld_q;
	logic skid_vld_q;
	logic up_valid;

	// the chain moves whenever the skid register is free
	assign en = !skid_vld_q;
	assign quat_ready = en;
	assign up_valid = vld_q[LAT-1] && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], quat_valid};
		end
	end

	// products
	always_ff @(posedge clk) begin
		if (en) begin
			w2_s1 <= quat.quat_w * quat.quat_w;
			x2_s1 <= quat.quat_x * quat.quat_x;
			y2_s1 <= quat.quat_y * quat.quat_y;
			z2_s1 <= quat.quat_z * quat.quat_z;
			wz_s1 <= quat.quat_w * quat.quat_z;
			xy_s1 <= quat.quat_x * quat.quat_y;
			wy_s1 <= quat.quat_w * quat.quat_y;
			xz_s1 <= quat.quat_x * quat.quat_z;
			wx_s1 <= quat.quat_w * quat.quat_x;
			yz_s1 <= quat.quat_y * quat.quat_z;
			w_s1 <= quat.quat_w;
			y_s1 <= quat.quat_y;
		end
	end

	// squared length, s and the atan2 operands
	always_ff @(posedge clk) begin
		if (en) begin
			len_s2 <= 33'(w2_s1) + 33'(x2_s1) + 33'(y2_s1) + 33'(z2_s1);
			s_s2 <= 33'(wx_s1) + 33'(yz_s1);
			yy_s2 <= (CW'(wz_s1) - CW'(xy_s1)) <<< 1;
			yx_s2 <= ONE_Q28 - ((CW'(z2_s1) + CW'(x2_s1)) <<< 1);
			ry_s2 <= (CW'(wy_s1) - CW'(xz_s1)) <<< 1;
			rx_s2 <= ONE_Q28 - ((CW'(y2_s1) + CW'(x2_s1)) <<< 1);
			sy_s2 <= CW'(y_s1) <<< 14;
			sw_s2 <= CW'(w_s1) <<< 14;
		end
	end

	// singularity bound
	always_ff @(posedge clk) begin
		if (en) begin
			bound_s3 <= len_s2 * BOUND_K;
			len_s3 <= len_s2;
			s_s3 <= s_s2;
			yy_s3 <= yy_s2;
			yx_s3 <= yx_s2;
			ry_s3 <= ry_s2;
			rx_s3 <= rx_s2;
			sy_s3 <= sy_s2;
			sw_s3 <= sw_s2;
		end
	end

	// singularity test and divider load
	assign lhs = {s_s3[32], s_s3, 30'd0};
	assign bnd = {1'b0, bound_s3};
	assign pos = lhs > bnd;
	assign neg = lhs < -bnd;
	assign s_mag = s_s3[32] ? -s_s3 : s_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			dvc[0].rem <= {s_mag[31:0], 31'd0};
			dvc[0].den <= len_s3;
			dvc[0].quo <= '0;
			side_q[0].yaw_y <= (pos || neg) ? sy_s3 : yy_s3;
			side_q[0].yaw_x <= (pos || neg) ? sw_s3 : yx_s3;
			side_q[0].roll_y <= ry_s3;
			side_q[0].roll_x <= rx_s3;
			side_q[0].mag <= '0;
			side_q[0].rneg <= s_s3[32];
			side_q[0].len_zero <= (len_s3 == '0);
			side_q[0].lock <= pos ? LOCK_POS : (neg ? LOCK_NEG : LOCK_NONE);
		end
	end

	// divider cells, most significant quotient bit first
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		qte_div_cell #(.BIT(DIV_STEPS - 1 - k)) u_cell (
			.clk(clk),
			.en(en),
			.d(dvc[k]),
			.q(dvc[k+1])
		);
	end

	// sideband delay line; the ratio joins it after the divider
	for (genvar j = 1; j < SIDE_N; j++) begin : g_side
		side_t side_d;

		always_comb begin
			side_d = side_q[j-1];
			if (j == SQ_IDX)
				side_d.mag = dvc[DIV_STEPS].quo;
		end

		always_ff @(posedge clk) begin
			if (en)
				side_q[j] <= side_d;
		end
	end

	// radicand 1 - r^2
	assign msq = dvc[DIV_STEPS].quo * dvc[DIV_STEPS].quo;

	always_ff @(posedge clk) begin
		if (en) begin
			sqc[0].rad <= 61'((62'd1 << 60) - msq);
			sqc[0].root <= '0;
		end
	end

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		qte_sqrt_cell #(.STEP(k)) u_cell (
			.clk(clk),
			.en(en),
			.d(sqc[k]),
			.q(sqc[k+1])
		);
	end

	// quadrant fold for the three atan2 chains
	always_ff @(posedge clk) begin
		if (en) begin
			yc[0] <= cord_pre(side_q[SIDE_N-1].yaw_y, side_q[SIDE_N-1].yaw_x);
			rc[0] <= cord_pre(side_q[SIDE_N-1].roll_y, side_q[SIDE_N-1].roll_x);
			pc[0] <= cord_pre(side_q[SIDE_N-1].rneg ? -CW'(side_q[SIDE_N-1].mag)
				: CW'(side_q[SIDE_N-1].mag), CW'(sqc[SQRT_STEPS].root[30:0]));
			tag_q[0].lock <= side_q[SIDE_N-1].lock;
			tag_q[0].len_zero <= side_q[SIDE_N-1].len_zero;
		end
	end

	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cord
		qte_cordic_cell #(.STAGE(k)) u_yaw (
			.clk(clk),
			.en(en),
			.d(yc[k]),
			.q(yc[k+1])
		);
		qte_cordic_cell #(.STAGE(k)) u_pitch (
			.clk(clk),
			.en(en),
			.d(pc[k]),
			.q(pc[k+1])
		);
		qte_cordic_cell #(.STAGE(k)) u_roll (
			.clk(clk),
			.en(en),
			.d(rc[k]),
			.q(rc[k+1])
		);
		always_ff @(posedge clk) begin
			if (en)
				tag_q[k+1] <= tag_q[k];
		end
	end

	// final scaling and the singular cases
	assign yaw2 = CW'(yc[CORDIC_STAGES].ang) <<< 1;

	always_comb begin
		res.lock_case = tag_q[CORDIC_STAGES].lock;
		case (tag_q[CORDIC_STAGES].lock)
			LOCK_POS: begin
				res.yaw_angle = to_field(yaw2);
				res.pitch_angle = PI_Q12;
				res.roll_angle = '0;
			end
			LOCK_NEG: begin
				res.yaw_angle = to_field(-yaw2);
				res.pitch_angle = -PI_Q12;
				res.roll_angle = '0;
			end
			default: begin
				res.yaw_angle = to_field(CW'(yc[CORDIC_STAGES].ang));
				res.pitch_angle = tag_q[CORDIC_STAGES].len_zero ? '0
					: to_field(CW'(pc[CORDIC_STAGES].ang));
				res.roll_angle = to_field(CW'(rc[CORDIC_STAGES].ang));
			end
		endcase
	end

	// output register with skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (up_valid) begin
			if (out_vld_q && !euler_ready)
				skid_vld_q <= 1'b1;
			else
				out_vld_q <= 1'b1;
		end else if (out_vld_q && euler_ready) begin
			if (skid_vld_q)
				skid_vld_q <= 1'b0;
			else
				out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid) begin
			if (out_vld_q && !euler_ready)
				skid_q <= res;
			else
				out_q <= res;
		end else if (out_vld_q && euler_ready && skid_vld_q) begin
			out_q <= skid_q;
		end
	end

	assign euler_valid = out_vld_q;
	assign euler = out_q;

`ifndef SYNTHESIS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid holds a request while the output register is empty");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(euler_valid && !euler_ready))
		else $error("skid filled without a stalled output");

	a_lock_code: assert property (@(posedge clk) disable iff (!arst_n)
		euler_valid |-> euler.lock_case != 2'd3)
		else $error("unused lock code on the output");

	a_lock_roll: assert property (@(posedge clk) disable iff (!arst_n)
		euler_valid && euler.lock_case != LOCK_NONE |->
			euler.roll_angle == '0 &&
			(euler.pitch_angle == PI_Q12 || euler.pitch_angle == -PI_Q12))
		else $error("singular result without fixed pitch and zero roll");
`endif

endmodule

@@ design/qte_div_cell.sv @@
module qte_div_cell #(
	parameter int BIT = 0
) (
	input logic clk,
	input logic en,
	input qte_pkg::div_t d,
	output qte_pkg::div_t q
);
	import qte_pkg::*;

	logic [63:0] trial;
	logic take;
	div_t nxt;
	div_t res_q;

	// one quotient bit: subtract the shifted divisor where it fits
	assign trial = {31'd0, d.den} << BIT;
	assign take = {1'b0, d.rem} >= trial;

	always_comb begin
		nxt = d;
		nxt.quo[BIT] = take;
		if (take)
			nxt.rem = d.rem - trial[62:0];
	end

	always_ff @(posedge clk) begin
		if (en)
			res_q <= nxt;
	end

	assign q = res_q;

endmodule

@@ design/qte_sqrt_cell.sv @@
module qte_sqrt_cell #(
	parameter int STEP = 0
) (
	input logic clk,
	input logic en,
	input qte_pkg::sqrt_t d,
	output qte_pkg::sqrt_t q
);
	import qte_pkg::*;

	localparam logic [61:0] BITV = 62'd1 << (60 - 2 * STEP);

	logic [61:0] trial;
	logic take;
	sqrt_t nxt;
	sqrt_t res_q;

	// one root bit per cell, digit by digit
	assign trial = d.root + BITV;
	assign take = {1'b0, d.rad} >= trial;

	always_comb begin
		nxt.rad = d.rad;
		nxt.root = d.root >> 1;
		if (take) begin
			nxt.rad = d.rad - trial[60:0];
			nxt.root = (d.root >> 1) + BITV;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			res_q <= nxt;
	end

	assign q = res_q;

endmodule

@@ design/qte_cordic_cell.sv @@
module qte_cordic_cell #(
	parameter int STAGE = 0
) (
	input logic clk,
	input logic en,
	input qte_pkg::cord_t d,
	output qte_pkg::cord_t q
);
	import qte_pkg::*;

	localparam logic signed [AW-1:0] ANG = stage_angle(STAGE);

	logic signed [CW-1:0] xs;
	logic signed [CW-1:0] ys;
	cord_t nxt;
	cord_t res_q;

	assign xs = d.x >>> STAGE;
	assign ys = d.y >>> STAGE;

	// rotate towards y = 0, accumulating the angle
	always_comb begin
		nxt = d;
		if (!d.hold) begin
			if (!d.y[CW-1]) begin
				nxt.x = d.x + ys;
				nxt.y = d.y - xs;
				nxt.ang = d.ang + ANG;
			end else begin
				nxt.x = d.x - ys;
				nxt.y = d.y + xs;
				nxt.ang = d.ang - ANG;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			res_q <= nxt;
	end

	assign q = res_q;

endmodule

@@ bench/tb_quaternion_to_euler_core.sv @@
module tb_quaternion_to_euler_core;
	import qte_pkg::*;

	localparam int STAGES = 16;
	localparam int N_RANDOM = 1930;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam longint PI_RAD_Q28 = 843314857;
	localparam longint PI_RAD_Q12 = 12868;
	localparam longint UNIT_Q28 = 268435456;
	localparam longint EPS_Q30 = 107;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic quat_valid = 1'b0;
	logic quat_ready;
	quat_t quat = '0;
	logic euler_valid;
	logic euler_ready = 1'b0;
	euler_t euler;

	quat_t pending_quats[$];
	euler_t expected_angles[$];
	int errors = 0;
	int received = 0;
	int send_gap = 0;
	int recv_gap = 0;
	int hold_off = 0;
	bit hold_done = 1'b0;
	int idle_cycles = 0;

	quaternion_to_euler_core #(.CORDIC_STAGES(STAGES)) uut (
		.clk(clk), .arst_n(arst_n),
		.quat_valid(quat_valid), .quat_ready(quat_ready), .quat(quat),
		.euler_valid(euler_valid), .euler_ready(euler_ready), .euler(euler)
	);

	always #5 clk = ~clk;

	// micro-rotation angle in Q.28
	function automatic longint rot_angle(input int i);
		longint tbl[10] = '{210828714, 124459457, 65760959, 33381290, 16755422,
			8385879, 4193963, 2097109, 1048571, 524287};
		if (i < 10)
			return tbl[i];
		if (i <= 28)
			return longint'(1) << (28 - i);
		return 0;
	endfunction

	// vectoring cordic atan2 in Q.28
	function automatic longint atan2_q28(input longint yy, input longint xx);
		longint ang;
		longint xs;
		longint ys;
		ang = 0;
		if (yy == 0)
			return (xx < 0) ? PI_RAD_Q28 : 0;
		if (xx < 0) begin
			ang = (yy > 0) ? PI_RAD_Q28 : -PI_RAD_Q28;
			xx = -xx;
			yy = -yy;
		end
		for (int i = 0; i < STAGES; i++) begin
			xs = xx >>> i;
			ys = yy >>> i;
			if (yy >= 0) begin
				xx = xx + ys;
				yy = yy - xs;
				ang += rot_angle(i);
			end else begin
				xx = xx - ys;
				yy = yy + xs;
				ang -= rot_angle(i);
			end
		end
		return ang;
	endfunction

	// floor integer square root
	function automatic longint unsigned root_floor(input longint unsigned v);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = longint'(1) << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// Q.28 to Q4.12 with round half up and saturation
	function automatic logic [15:0] q28_to_q12(input longint a);
		longint v;
		v = (a + 32768) >>> 16;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[15:0];
	endfunction

	// expected euler angles of one quaternion
	function automatic euler_t euler_of(input quat_t q);
		euler_t e;
		longint w, x, y, z, len, s, lhs, bound, num, a, r;
		longint unsigned mag, r2, c;
		w = q.quat_w;
		x = q.quat_x;
		y = q.quat_y;
		z = q.quat_z;
		len = w * w + x * x + y * y + z * z;
		s = w * x + y * z;
		lhs = s * (UNIT_Q28 * 4);
		bound = (UNIT_Q28 * 2 - EPS_Q30) * len;
		if (lhs > bound || lhs < -bound) begin
			a = 2 * atan2_q28(y * 16384, w * 16384);
			if (lhs > bound) begin
				e.yaw_angle = q28_to_q12(a);
				e.pitch_angle = 16'(PI_RAD_Q12);
				e.lock_case = LOCK_POS;
			end else begin
				e.yaw_angle = q28_to_q12(-a);
				e.pitch_angle = 16'(-PI_RAD_Q12);
				e.lock_case = LOCK_NEG;
			end
			e.roll_angle = '0;
			return e;
		end
		e.yaw_angle = q28_to_q12(atan2_q28(2 * (w * z - x * y),
			UNIT_Q28 - 2 * (z * z + x * x)));
		e.roll_angle = q28_to_q12(atan2_q28(2 * (w * y - x * z),
			UNIT_Q28 - 2 * (y * y + x * x)));
		e.pitch_angle = '0;
		if (len != 0) begin
			num = 2 * s * (UNIT_Q28 * 4);
			mag = longint'(num < 0 ? -num : num) / longint'(len);
			if (mag > (longint'(1) << 30))
				mag = longint'(1) << 30;
			r = num < 0 ? -longint'(mag) : longint'(mag);
			r2 = mag * mag;
			c = (r2 >= (longint'(1) << 60)) ? 0 : root_floor((longint'(1) << 60) - r2);
			e.pitch_angle = q28_to_q12(atan2_q28(r, longint'(c)));
		end
		e.lock_case = LOCK_NONE;
		return e;
	endfunction

	function automatic quat_t mk(input int w, input int x, input int y, input int z);
		quat_t q;
		q.quat_w = w[15:0];
		q.quat_x = x[15:0];
		q.quat_y = y[15:0];
		q.quat_z = z[15:0];
		return q;
	endfunction

	function automatic int srand(input int lim);
		return int'($urandom_range(0, 2 * lim)) - lim;
	endfunction

	// random quaternion: mostly unit-scale and near-lock, some raw bit noise and near-zero inputs
	function automatic quat_t random_quat();
		int sel, a, b;
		sel = $urandom_range(0, 9);
		if (sel <= 2)
			return quat_t'({$urandom, $urandom});
		if (sel <= 6)
			return mk(srand(16384), srand(16384), srand(16384), srand(16384));
		a = srand(16384);
		b = srand(16384);
		if (sel <= 8) begin
			if ($urandom_range(0, 1))
				return mk(a, a + srand(4), b, b + srand(4));
			return mk(a, -a + srand(4), b, -b + srand(4));
		end
		return mk(srand(3), srand(3), srand(3), srand(3));
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_valid <= 1'b0;
		end else begin
			if (quat_valid && quat_ready)
				expected_angles.push_back(euler_of(quat));
			if (!(quat_valid && !quat_ready)) begin
				if (send_gap > 0) begin
					send_gap--;
					quat_valid <= 1'b0;
				end else if (pending_quats.size() > 0) begin
					quat <= pending_quats.pop_front();
					quat_valid <= 1'b1;
					if (pending_quats.size() > 200 && $urandom_range(0, 11) == 0)
						send_gap = $urandom_range(1, 14);
				end else begin
					quat_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor with random back-pressure and one long hold-off
	always @(posedge clk or negedge arst_n) begin
		euler_t want;
		if (!arst_n) begin
			euler_ready <= 1'b0;
		end else begin
			if (euler_valid && euler_ready) begin
				received++;
				if (expected_angles.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result %p", euler);
				end else begin
					want = expected_angles.pop_front();
					if (euler !== want) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected %p, got %p", want, euler);
					end
				end
			end
			if (!hold_done && received == 300) begin
				hold_done = 1'b1;
				hold_off = 400;
			end
			if (hold_off > 0) begin
				hold_off--;
				euler_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				euler_ready <= 1'b0;
			end else begin
				euler_ready <= 1'b1;
				if (pending_quats.size() > 200 && $urandom_range(0, 9) == 0)
					recv_gap = $urandom_range(1, 14);
			end
		end
	end

	// watchdog on cycles without any accepted request or result
	always @(posedge clk) begin
		if ((quat_valid && quat_ready) || (euler_valid && euler_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		// directed: extremes, lock cases, zero and axis-aligned inputs
		pending_quats.push_back(mk(0, 0, 0, 0));
		pending_quats.push_back(mk(16384, 0, 0, 0));
		pending_quats.push_back(mk(-16384, 0, 0, 0));
		pending_quats.push_back(mk(32767, 32767, 32767, 32767));
		pending_quats.push_back(mk(-32768, -32768, -32768, -32768));
		pending_quats.push_back(mk(32767, -32768, 32767, -32768));
		pending_quats.push_back(mk(8192, 8192, 8192, 8192));
		pending_quats.push_back(mk(8192, -8192, 8192, -8192));
		pending_quats.push_back(mk(11585, 11585, 0, 0));
		pending_quats.push_back(mk(11585, -11585, 0, 0));
		pending_quats.push_back(mk(-11585, 11585, 0, 0));
		pending_quats.push_back(mk(0, 0, 11585, 11585));
		pending_quats.push_back(mk(8192, 8190, 8192, 8192));
		pending_quats.push_back(mk(0, 16384, 0, 0));
		pending_quats.push_back(mk(0, 0, 16384, 0));
		pending_quats.push_back(mk(0, 0, 0, 16384));
		pending_quats.push_back(mk(0, 0, 0, -16384));
		pending_quats.push_back(mk(-16384, 0, 0, 1));
		pending_quats.push_back(mk(32767, 0, 0, 0));
		pending_quats.push_back(mk(1, 0, 0, 0));
		pending_quats.push_back(mk(-1, -1, 1, 1));
		pending_quats.push_back(mk(1, 0, 0, 0) ^ quat_t'(64'h8000_0000_0000_0000));
		for (int i = 0; i < N_RANDOM; i++)
			pending_quats.push_back(random_quat());
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_quats.size() == 0 && !quat_valid && expected_angles.size() == 0);
		repeat (150) @(posedge clk);
		if (expected_angles.size() != 0)
			errors++;
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ quaternion_to_euler_core.f @@
design/qte_pkg.sv
design/qte_div_cell.sv
design/qte_sqrt_cell.sv
design/qte_cordic_cell.sv
design/quaternion_to_euler_core.sv
bench/tb_quaternion_to_euler_core.sv
